FILE: rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and the microprogram of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

   localparam int COLUMNS_DEF   = 80;
   localparam int ROWS_DEF      = 25;
   localparam int TAB_WIDTH_DEF = 8;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CODE_W = 8;
   localparam int CLR_W  = 4;
   localparam int UPC_W  = 4;

   localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;
   localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSEL_ITEM,
      CSEL_ZERO,
      CSEL_SPACE
   } code_sel_type;

   typedef enum logic {
      COLSEL_CUR,
      COLSEL_SCAN
   } col_sel_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_COL_CLR,
      ACT_ROW_INC_COL_CLR,
      ACT_COL_INC,
      ACT_COL_TARGET,
      ACT_SCAN_INC,
      ACT_REJ
   } act_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_NOT_LAST_ROW,
      COND_LAST_COL,
      COND_SCAN_BELOW
   } cond_type;

   typedef struct packed {
      logic         emit;
      kind_type     kind;
      code_sel_type code_sel;
      col_sel_type  col_sel;
      act_type      act;
      cond_type     cond;
      upc_type      target;
   } uword_type;

   // sequencer -> datapath
   typedef struct packed {
      logic      load;   // item accepted this cycle
      logic      fire;   // current step completes this cycle
      uword_type uword;
   } ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic at_last_col;
      logic at_last_row;
      logic scan_below;
      logic out_free;
   } status_type;

   // microprogram addresses
   localparam upc_type UA_IDLE    = 4'd0;
   localparam upc_type UA_NL      = 4'd1;
   localparam upc_type UA_SCROLL  = 4'd2;
   localparam upc_type UA_ROW_INC = 4'd3;
   localparam upc_type UA_CR      = 4'd4;
   localparam upc_type UA_DONE    = 4'd5;
   localparam upc_type UA_TAB     = 4'd6;
   localparam upc_type UA_FILL    = 4'd7;
   localparam upc_type UA_SPACE   = 4'd8;
   localparam upc_type UA_REJ     = 4'd9;
   localparam upc_type UA_PRINT   = 4'd10;
   localparam upc_type UA_COL_INC = 4'd11;

   function automatic uword_type mk_word(logic emit, kind_type kind, code_sel_type csel,
                                         col_sel_type colsel, act_type act,
                                         cond_type cond, upc_type target);
      uword_type w;
      w.emit     = emit;
      w.kind     = kind;
      w.code_sel = csel;
      w.col_sel  = colsel;
      w.act      = act;
      w.cond     = cond;
      w.target   = target;
      return w;
   endfunction

   function automatic uword_type ucode_rom(upc_type addr);
      uword_type w;
      case (addr)
         UA_IDLE:    w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_NONE,
                                 COND_DISPATCH, UA_IDLE);
         UA_NL:      w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_NONE,
                                 COND_NOT_LAST_ROW, UA_ROW_INC);
         UA_SCROLL:  w = mk_word(1'b1, KIND_SCROLL, CSEL_ZERO, COLSEL_CUR, ACT_COL_CLR,
                                 COND_ALWAYS, UA_DONE);
         UA_ROW_INC: w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR,
                                 ACT_ROW_INC_COL_CLR, COND_ALWAYS, UA_DONE);
         UA_CR:      w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_COL_CLR,
                                 COND_ALWAYS, UA_DONE);
         UA_DONE:    w = mk_word(1'b1, KIND_DONE, CSEL_ZERO, COLSEL_CUR, ACT_NONE,
                                 COND_ALWAYS, UA_IDLE);
         UA_TAB:     w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_NONE,
                                 COND_LAST_COL, UA_REJ);
         UA_FILL:    w = mk_word(1'b1, KIND_WRITE, CSEL_ZERO, COLSEL_SCAN, ACT_SCAN_INC,
                                 COND_SCAN_BELOW, UA_FILL);
         UA_SPACE:   w = mk_word(1'b1, KIND_WRITE, CSEL_SPACE, COLSEL_SCAN, ACT_COL_TARGET,
                                 COND_ALWAYS, UA_DONE);
         UA_REJ:     w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_REJ,
                                 COND_ALWAYS, UA_DONE);
         UA_PRINT:   w = mk_word(1'b1, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_NONE,
                                 COND_LAST_COL, UA_NL);
         UA_COL_INC: w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_COL_INC,
                                 COND_ALWAYS, UA_DONE);
         default:    w = mk_word(1'b0, KIND_WRITE, CSEL_ITEM, COLSEL_CUR, ACT_NONE,
                                 COND_ALWAYS, UA_IDLE);
      endcase
      return w;
   endfunction

   // entry point of the program for a character code
   function automatic upc_type dispatch(logic [CODE_W-1:0] code);
      upc_type a;
      case (code)
         CODE_NEWLINE: a = UA_NL;
         CODE_RETURN:  a = UA_CR;
         CODE_TAB:     a = UA_TAB;
         default:      a = UA_PRINT;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tcce_sequencer.sv
// ----------------------------------------------------------------------------
// tcce_sequencer
// Microprogram counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_sequencer
   import tcce_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [CODE_W-1:0] req_code,
   input  wire status_type        status,
   output logic                   req_ready,
   output ctrl_type               ctrl
);

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type uw;
   logic      fire;

   assign uw = ucode_rom(upc_ff);

   always_comb begin
      if (uw.cond == COND_DISPATCH) begin
         fire = req_valid;
      end else begin
         // a step that emits waits for the output register
         fire = !uw.emit || status.out_free;
      end
   end

   assign req_ready  = (uw.cond == COND_DISPATCH);
   assign ctrl.load  = req_ready && req_valid;
   assign ctrl.fire  = fire;
   assign ctrl.uword = uw;

   always_comb begin
      upc_in = upc_ff;
      if (fire) begin
         case (uw.cond)
            COND_NEXT:         upc_in = upc_ff + upc_type'(1);
            COND_ALWAYS:       upc_in = uw.target;
            COND_DISPATCH:     upc_in = dispatch(req_code);
            COND_NOT_LAST_ROW: upc_in = !status.at_last_row ? uw.target
                                                            : upc_ff + upc_type'(1);
            COND_LAST_COL:     upc_in = status.at_last_col ? uw.target
                                                           : upc_ff + upc_type'(1);
            COND_SCAN_BELOW:   upc_in = status.scan_below ? uw.target
                                                          : upc_ff + upc_type'(1);
            default:           upc_in = UA_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcce_datapath.sv
// ----------------------------------------------------------------------------
// tcce_datapath
// Cursor, item and tab scan registers plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_datapath
   import tcce_pkg::*;
#(
   parameter int COLUMNS   = COLUMNS_DEF,
   parameter int ROWS      = ROWS_DEF,
   parameter int TAB_WIDTH = TAB_WIDTH_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CODE_W-1:0] req_code,
   input  wire logic [CLR_W-1:0]  req_back,
   input  wire logic [CLR_W-1:0]  req_fore,
   input  wire ctrl_type          ctrl,
   input  wire logic              rsp_ready,
   output status_type             status,
   output logic                   rsp_valid,
   output kind_type               rsp_kind,
   output logic [COL_W-1:0]       rsp_col,
   output logic [ROW_W-1:0]       rsp_row,
   output logic [CODE_W-1:0]      rsp_code,
   output logic [CLR_W-1:0]       rsp_back,
   output logic [CLR_W-1:0]       rsp_fore,
   output logic                   rsp_rej,
   output logic                   rsp_last
);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]   TAB_STEP = (COL_W + 1)'(TAB_WIDTH);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  scan_ff, scan_in;
   logic [COL_W-1:0]  target_ff, target_in;
   logic              rej_ff, rej_in;
   logic [CODE_W-1:0] code_ff;
   logic [CLR_W-1:0]  back_ff, fore_ff;
   logic [COL_W:0]    tab_sum;

   logic              out_valid_ff, out_valid_in;
   kind_type          out_kind_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [CODE_W-1:0] out_code_ff;
   logic [CLR_W-1:0]  out_back_ff, out_fore_ff;
   logic              out_rej_ff, out_last_ff;
   logic              out_load;
   uword_type         uw;

   assign uw = ctrl.uword;

   assign status.at_last_col = (col_ff >= LAST_COL);
   assign status.at_last_row = (row_ff >= LAST_ROW);
   assign status.scan_below  = ({1'b0, scan_ff} + (COL_W + 1)'(1)) < {1'b0, target_ff};
   assign status.out_free    = !out_valid_ff || rsp_ready;

   // tab stop, clamped to the last column
   assign tab_sum = {1'b0, col_ff} + TAB_STEP;

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      scan_in   = scan_ff;
      target_in = target_ff;
      rej_in    = rej_ff;
      if (ctrl.load) begin
         scan_in   = col_ff;
         target_in = (tab_sum >= {1'b0, LAST_COL}) ? LAST_COL : tab_sum[COL_W-1:0];
         rej_in    = 1'b0;
      end else if (ctrl.fire) begin
         case (uw.act)
            ACT_NONE: begin
            end
            ACT_COL_CLR: begin
               col_in = '0;
            end
            ACT_ROW_INC_COL_CLR: begin
               row_in = row_ff + ROW_W'(1);
               col_in = '0;
            end
            ACT_COL_INC: begin
               col_in = col_ff + COL_W'(1);
            end
            ACT_COL_TARGET: begin
               col_in = target_ff;
            end
            ACT_SCAN_INC: begin
               scan_in = scan_ff + COL_W'(1);
            end
            ACT_REJ: begin
               rej_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      target_ff <= target_in;
      rej_ff    <= rej_in;
      if (ctrl.load) begin
         code_ff <= req_code;
         back_ff <= req_back;
         fore_ff <= req_fore;
      end
   end

   // result register
   assign out_load = ctrl.fire && uw.emit && !ctrl.load;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff <= uw.kind;
         case (uw.kind)
            KIND_WRITE: begin
               out_col_ff  <= (uw.col_sel == COLSEL_SCAN) ? scan_ff : col_ff;
               out_row_ff  <= row_ff;
               case (uw.code_sel)
                  CSEL_ITEM:  out_code_ff <= code_ff;
                  CSEL_SPACE: out_code_ff <= CODE_SPACE;
                  default:    out_code_ff <= '0;
               endcase
               out_back_ff <= back_ff;
               out_fore_ff <= fore_ff;
               out_rej_ff  <= 1'b0;
               out_last_ff <= 1'b0;
            end
            KIND_DONE: begin
               out_col_ff  <= col_ff;
               out_row_ff  <= row_ff;
               out_code_ff <= '0;
               out_back_ff <= '0;
               out_fore_ff <= '0;
               out_rej_ff  <= rej_ff;
               out_last_ff <= 1'b1;
            end
            default: begin
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_code_ff <= '0;
               out_back_ff <= '0;
               out_fore_ff <= '0;
               out_rej_ff  <= 1'b0;
               out_last_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_code  = out_code_ff;
   assign rsp_back  = out_back_ff;
   assign rsp_fore  = out_fore_ff;
   assign rsp_rej   = out_rej_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_engine_core.sv
// Steps: a printed character writes its cell, then advances the column or, at the last
// column, runs newline; carriage return clears the column; newline clears it and moves
// down a row, or scrolls on the last row; tab fills cells up to its stop and writes a
// space there, or is rejected at the last column. Each item ends with a done item.
// Throughput: one microprogram step per cycle; a step that emits waits while the result is held.
// Reset: synchronous; cursor goes to column 0, row 0, program to its idle step.
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Cursor control for a text console: microcoded sequencer plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_core
   import tcce_pkg::*;
#(
   parameter int COLUMNS   = COLUMNS_DEF,
   parameter int ROWS      = ROWS_DEF,
   parameter int TAB_WIDTH = TAB_WIDTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // char_code[7:0], back_color[11:8], fore_color[15:12]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // cell_col[6:0], cell_row[11:7], cell_code[19:12],
                                        // cell_back[23:20], cell_fore[27:24], rejected[28]
   output logic [1:0]       rsp_tuser,  // kind[1:0]
   output logic             rsp_tlast   // last_of_run
);

   status_type        status;
   ctrl_type          ctrl;
   kind_type          rsp_kind;
   logic [COL_W-1:0]  rsp_col;
   logic [ROW_W-1:0]  rsp_row;
   logic [CODE_W-1:0] rsp_code;
   logic [CLR_W-1:0]  rsp_back, rsp_fore;
   logic              rsp_rej;

   tcce_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_code  (req_tdata[7:0]),
      .status    (status),
      .req_ready (req_tready),
      .ctrl      (ctrl)
   );

   tcce_datapath #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_code  (req_tdata[7:0]),
      .req_back  (req_tdata[11:8]),
      .req_fore  (req_tdata[15:12]),
      .ctrl      (ctrl),
      .rsp_ready (rsp_tready),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_kind  (rsp_kind),
      .rsp_col   (rsp_col),
      .rsp_row   (rsp_row),
      .rsp_code  (rsp_code),
      .rsp_back  (rsp_back),
      .rsp_fore  (rsp_fore),
      .rsp_rej   (rsp_rej),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_rej, rsp_fore, rsp_back, rsp_code, rsp_row, rsp_col};
   assign rsp_tuser = rsp_kind;

`ifndef SYNTHESIS
   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_DONE)
      else $error("run ended on an item that is not done");

   a_rej_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28] |-> rsp_tlast)
      else $error("rejected flag on a non-final item");

   a_scroll_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SCROLL |-> rsp_tdata == 32'd0)
      else $error("scroll item carries nonzero fields");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DONE |->
         rsp_tdata[6:0] <= COL_W'(COLUMNS - 1) && rsp_tdata[11:7] <= ROW_W'(ROWS - 1))
      else $error("cursor left the grid");
`endif

endmodule

`default_nettype wire

FILE: dv/text_console_cursor_engine_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core_tb
// Streams character items into the cursor engine and checks every cell write,
// scroll and done item against a cursor model kept in the bench. Both stream
// sides idle at random, with a quiet stretch at the end of the run.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core_tb;
   import tcce_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS     = COLUMNS_DEF;
   localparam int ROWS        = ROWS_DEF;
   localparam int TAB_WIDTH   = TAB_WIDTH_DEF;
   localparam int RAND_ITEMS  = 430;
   localparam int CALM_ITEMS  = 60;     // last items run with no idling
   localparam int TAIL_CYCLES = 32;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic [CLR_W-1:0]  back;
      logic [CLR_W-1:0]  fore;
      bit                drain;   // hold until all earlier runs have finished
   } glyph_type;

   typedef struct packed {
      kind_type          kind;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CODE_W-1:0] code;
      logic [CLR_W-1:0]  back;
      logic [CLR_W-1:0]  fore;
      logic              rej;
      logic              last;
   } cell_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // char_code[7:0], back_color[11:8], fore_color[15:12]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // cell_col[6:0], cell_row[11:7], cell_code[19:12],
                                  // cell_back[23:20], cell_fore[27:24], rejected[28]
   logic [1:0]  rsp_tuser;        // kind[1:0]
   logic        rsp_tlast;        // last_of_run

   glyph_type     glyph_q[$];
   cell_cmd_type  cell_cmd_q[$];
   int            total_items = 0;
   int            accepted_cnt = 0;
   int            finished_cnt = 0;
   int            mismatches = 0;
   int            cycles = 0;

   // cursor model
   logic [COL_W-1:0] cur_col = '0;
   logic [ROW_W-1:0] cur_row = '0;

   text_console_cursor_engine_core #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void push_cmd(kind_type kind, int col, int row, logic [CODE_W-1:0] code,
                                    logic [CLR_W-1:0] back, logic [CLR_W-1:0] fore,
                                    logic rej, logic last);
      cell_cmd_type c;
      c.kind = kind;
      c.col  = COL_W'(col);
      c.row  = ROW_W'(row);
      c.code = code;
      c.back = back;
      c.fore = fore;
      c.rej  = rej;
      c.last = last;
      cell_cmd_q.push_back(c);
   endfunction

   // next row, scrolling the screen when already on the bottom row
   function automatic void feed_line();
      if (int'(cur_row) >= ROWS - 1) begin
         push_cmd(KIND_SCROLL, 0, 0, '0, '0, '0, 1'b0, 1'b0);
         cur_row = ROW_W'(ROWS - 1);
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endfunction

   function automatic void advance_cursor(glyph_type g);
      int  target;
      logic rej;
      rej = 1'b0;
      if (g.code == CODE_NEWLINE) begin
         feed_line();
         cur_col = '0;
      end else if (g.code == CODE_RETURN) begin
         cur_col = '0;
      end else if (g.code == CODE_TAB) begin
         if (int'(cur_col) >= COLUMNS - 1) begin
            rej = 1'b1;
         end else begin
            target = int'(cur_col) + TAB_WIDTH;
            if (target >= COLUMNS - 1)
               target = COLUMNS - 1;
            for (int c = int'(cur_col); c < target; c++)
               push_cmd(KIND_WRITE, c, int'(cur_row), '0, g.back, g.fore, 1'b0, 1'b0);
            cur_col = COL_W'(target);
            push_cmd(KIND_WRITE, int'(cur_col), int'(cur_row), CODE_SPACE, g.back, g.fore,
                     1'b0, 1'b0);
         end
      end else begin
         push_cmd(KIND_WRITE, int'(cur_col), int'(cur_row), g.code, g.back, g.fore,
                  1'b0, 1'b0);
         if (int'(cur_col) >= COLUMNS - 1) begin
            feed_line();
            cur_col = '0;
         end else begin
            cur_col = cur_col + 1'b1;
         end
      end
      push_cmd(KIND_DONE, int'(cur_col), int'(cur_row), '0, '0, '0, rej, 1'b1);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void add_glyph(logic [CODE_W-1:0] code, logic [CLR_W-1:0] back,
                                     logic [CLR_W-1:0] fore, bit drain);
      glyph_type g;
      g.code  = code;
      g.back  = back;
      g.fore  = fore;
      g.drain = drain;
      glyph_q.push_back(g);
   endfunction

   // stimulus
   initial begin
      int pick;
      logic [CODE_W-1:0] code;

      // extremes of code and colors, then the control codes
      add_glyph(8'h00, 4'h0, 4'h0, 1'b0);
      add_glyph(8'hFF, 4'hF, 4'hF, 1'b0);
      add_glyph(CODE_RETURN, 4'h5, 4'hA, 1'b0);
      add_glyph(CODE_NEWLINE, 4'hA, 4'h5, 1'b0);
      // tabs walk to the last column, the last one clamped
      for (int i = 0; i < 10; i++)
         add_glyph(CODE_TAB, 4'(i), 4'(15 - i), 1'b0);
      add_glyph(CODE_TAB, 4'hF, 4'h0, 1'b0);       // refused at last column
      add_glyph(8'h41, 4'h3, 4'hC, 1'b1);          // print at last column wraps
      add_glyph(CODE_NEWLINE, 4'h0, 4'hF, 1'b0);
      add_glyph(CODE_RETURN, 4'hF, 4'h0, 1'b0);
      add_glyph(CODE_TAB, 4'hF, 4'hF, 1'b0);
      add_glyph(CODE_SPACE, 4'h9, 4'h6, 1'b0);
      add_glyph(8'h08, 4'h1, 4'h2, 1'b0);
      add_glyph(8'h0B, 4'h4, 4'h8, 1'b0);
      add_glyph(8'h0E, 4'h7, 4'hE, 1'b0);
      add_glyph(8'h80, 4'hC, 4'h3, 1'b0);

      // random text; part of every hundred items has no line breaks so the
      // cursor reaches the last column and wraps
      for (int i = 0; i < RAND_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         code = 8'($urandom_range(0, 255));
         if (i % 100 >= 30 && pick < 12)
            code = CODE_NEWLINE;
         else if (i % 100 >= 30 && pick < 17)
            code = CODE_RETURN;
         else if (pick >= 17 && pick < 42)
            code = CODE_TAB;
         add_glyph(code, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   i == 0 || (i % 60 == 59 && i < RAND_ITEMS - CALM_ITEMS));
      end
      total_items = glyph_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cnt != total_items || cell_cmd_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && cell_cmd_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // item driver
   int        send_gap = 0;
   glyph_type cur_glyph;

   always @(posedge clock) begin
      logic take;
      logic calm;
      take = req_tvalid && req_tready;
      calm = accepted_cnt >= total_items - CALM_ITEMS;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (take) begin
            advance_cursor(cur_glyph);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else if (glyph_q.size() != 0 &&
                      (!glyph_q[0].drain || (!take && accepted_cnt == finished_cnt))) begin
            cur_glyph = glyph_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_glyph.fore, cur_glyph.back, cur_glyph.code};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   int recv_stall = 0;

   always @(posedge clock) begin
      cell_cmd_type want;
      logic calm;
      calm = accepted_cnt >= total_items - CALM_ITEMS;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cell_cmd_q.size() == 0) begin
               $error("unexpected item: kind %0d tdata %h last %b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = cell_cmd_q.pop_front();
               check_field("kind",        int'(want.kind), int'(rsp_tuser));
               check_field("cell_col",    int'(want.col),  int'(rsp_tdata[6:0]));
               check_field("cell_row",    int'(want.row),  int'(rsp_tdata[11:7]));
               check_field("cell_code",   int'(want.code), int'(rsp_tdata[19:12]));
               check_field("cell_back",   int'(want.back), int'(rsp_tdata[23:20]));
               check_field("cell_fore",   int'(want.fore), int'(rsp_tdata[27:24]));
               check_field("rejected",    int'(want.rej),  int'(rsp_tdata[28]));
               check_field("last_of_run", int'(want.last), int'(rsp_tlast));
            end
            if (rsp_tlast)
               finished_cnt <= finished_cnt + 1;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
